// ===== design/dgpw_pkg.sv =====
// Shared types, constants and the 4x5 digit font for the digit glyph pixel writer.
// No dependencies; the sequencer, the datapath and the top level import this package.
package dgpw_pkg;

  localparam int unsigned FRAME_WORDS_DEF = 1048576;

  localparam int CHAR_W   = 8;
  localparam int STRIDE_W = 13;
  localparam int COORD_W  = 12;
  localparam int COLOR_W  = 32;
  localparam int INDEX_W  = 24;
  localparam int PEN_W    = 16;
  // Pixel row: origin_y plus at most 11.
  localparam int ROW_W    = 13;
  // Row base: pixel row times stride.
  localparam int BASE_W   = 26;
  // Full index before truncation: row base plus pen plus glyph offset.
  localparam int FULL_W   = 27;
  localparam int XOFF_W   = 4;

  localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_NINE = 8'h39;
  localparam logic [CHAR_W-1:0] CHAR_DOT  = 8'h2E;

  localparam logic [3:0] DOT_Y_OFFSET = 4'd10;
  localparam logic [3:0] DIGIT_ADVANCE = 4'd10;
  localparam logic [3:0] DOT_ADVANCE   = 4'd4;
  localparam logic [PEN_W-1:0] PEN_MAX = 16'hFFFF;

  localparam logic [STRIDE_W-1:0] ROW_STRIDE_RST = 13'd640;
  localparam logic [COLOR_W-1:0]  INK_COLOR_RST  = 32'hFF0000FF;

  // Font rows packed top to bottom, row 0 in the top nibble.
  localparam logic [19:0] FONT_ROWS [10] = '{
    20'hF999F, 20'h11111, 20'hF1F8F, 20'hF1F1F, 20'h99F11,
    20'hF8F1F, 20'hF8F9F, 20'hF1224, 20'hF9F9F, 20'hF9F1F
  };

  typedef enum logic [1:0] {
    REG_ROW_STRIDE = 2'd0,
    REG_ORIGIN_X   = 2'd1,
    REG_ORIGIN_Y   = 2'd2,
    REG_INK_COLOR  = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [CHAR_W-1:0] character;
    logic              string_start;
  } char_req_t;

  typedef struct packed {
    logic [INDEX_W-1:0] pixel_index;
    logic [COLOR_W-1:0] pixel_value;
    logic               out_of_range;
    logic               last_write;
  } pixel_wr_t;

  typedef struct packed {
    cfg_reg_t           reg_index;
    logic [COLOR_W-1:0] wdata;
  } cfg_wr_t;

  // Commands from the sequencer to the datapath.
  typedef struct packed {
    logic              load_pen;
    logic              load_top;
    logic              dot_row;
    logic              load_bot;
    logic              emit;
    logic              dy;
    logic [XOFF_W-1:0] xoff;
    logic              last;
    logic              next_row;
    logic              advance_pen;
    logic              dot_advance;
  } dp_cmd_t;

  // Status from the datapath to the sequencer.
  typedef struct packed {
    logic emit_ok;
  } dp_status_t;

  function automatic logic [3:0] glyph_row(input logic [3:0] digit, input logic [2:0] row);
    logic [19:0] word;
    logic [3:0]  bits;
    word = (digit <= 4'd9) ? FONT_ROWS[digit] : 20'h00000;
    case (row)
      3'd0:    bits = word[19:16];
      3'd1:    bits = word[15:12];
      3'd2:    bits = word[11:8];
      3'd3:    bits = word[7:4];
      3'd4:    bits = word[3:0];
      default: bits = 4'b0000;
    endcase
    return bits;
  endfunction

endpackage

// ===== design/dgpw_stream_if.sv =====
// Generic valid/ready channel used for characters, pixel writes and register writes.
// The payload type comes from dgpw_pkg at the point of instantiation.
interface dgpw_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== design/dgpw_ctrl.sv =====
// Sequencer for the digit glyph pixel writer: walks font rows, lit columns and 2x2 blocks.
// Depends on dgpw_pkg; drives dgpw_datapath through dp_cmd_t.
module dgpw_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  input  dgpw_pkg::char_req_t   req,
  output logic                  req_ready,
  input  dgpw_pkg::dp_status_t  status,
  output dgpw_pkg::dp_cmd_t     cmd
);
  import dgpw_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE     = 4'b0001,
    ST_LOAD_TOP = 4'b0010,
    ST_LOAD_BOT = 4'b0100,
    ST_EMIT     = 4'b1000
  } ctrl_state_t;

  typedef struct packed {
    logic       found;
    logic [1:0] col;
  } lit_t;

  // Column c draws font bit 3-c; find the first lit column at or after start.
  function automatic lit_t first_lit(input logic [3:0] bits, input logic [2:0] start);
    lit_t res;
    res = '0;
    for (int i = 0; i < 4; i++) begin
      if (!res.found && (3'(i) >= start) && bits[3-i]) begin
        res.found = 1'b1;
        res.col   = 2'(i);
      end
    end
    return res;
  endfunction

  ctrl_state_t state, state_next;
  logic [3:0]  glyph, glyph_next;
  logic        is_dot, is_dot_next;
  logic [2:0]  row, row_next;
  logic [1:0]  col, col_next;
  logic        dy, dy_next;
  logic        dx, dx_next;

  logic [3:0]  cur_bits;
  logic [3:0]  nxt_bits;
  logic        last_row;
  logic        blk_end;
  lit_t        lit_cur;
  lit_t        lit_after;
  lit_t        lit_nxt;
  logic        is_digit;

  assign is_digit  = (req.character >= CHAR_ZERO) && (req.character <= CHAR_NINE);
  assign cur_bits  = is_dot ? 4'b1000 : glyph_row(glyph, row);
  assign nxt_bits  = glyph_row(glyph, row + 3'd1);
  assign last_row  = is_dot || (row == 3'd4);
  assign blk_end   = dy && dx;
  assign lit_cur   = first_lit(cur_bits, 3'd0);
  assign lit_after = first_lit(cur_bits, {1'b0, col} + 3'd1);
  assign lit_nxt   = first_lit(nxt_bits, 3'd0);

  always_comb begin
    state_next  = state;
    glyph_next  = glyph;
    is_dot_next = is_dot;
    row_next    = row;
    col_next    = col;
    dy_next     = dy;
    dx_next     = dx;
    cmd         = '0;
    req_ready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.load_pen = req.string_start;
          row_next     = 3'd0;
          glyph_next   = 4'(req.character - CHAR_ZERO);
          is_dot_next  = (req.character == CHAR_DOT);
          if (is_digit || (req.character == CHAR_DOT)) begin
            state_next = ST_LOAD_TOP;
          end
        end
      end
      ST_LOAD_TOP: begin
        cmd.load_top = 1'b1;
        cmd.dot_row  = is_dot;
        state_next   = ST_LOAD_BOT;
      end
      ST_LOAD_BOT: begin
        cmd.load_bot = 1'b1;
        col_next     = lit_cur.col;
        dy_next      = 1'b0;
        dx_next      = 1'b0;
        state_next   = ST_EMIT;
      end
      ST_EMIT: begin
        if (status.emit_ok) begin
          cmd.emit = 1'b1;
          cmd.dy   = dy;
          cmd.xoff = {3'({1'b0, col} + 3'd1), dx};
          cmd.last = blk_end && !lit_after.found && last_row;
          dx_next  = !dx;
          if (dx) begin
            dy_next = !dy;
          end
          if (blk_end) begin
            if (lit_after.found) begin
              col_next = lit_after.col;
            end else if (!last_row) begin
              cmd.next_row = 1'b1;
              row_next     = row + 3'd1;
              col_next     = lit_nxt.col;
            end else begin
              cmd.advance_pen = 1'b1;
              cmd.dot_advance = is_dot;
              state_next      = ST_IDLE;
            end
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    glyph  <= glyph_next;
    is_dot <= is_dot_next;
    row    <= row_next;
    col    <= col_next;
    dy     <= dy_next;
    dx     <= dx_next;
  end

  // The pen moves only together with the final write of a character.
  a_adv_on_last: assert property (@(posedge clk) disable iff (rst)
    cmd.advance_pen |-> (cmd.emit && cmd.last))
    else $error("pen advanced without the final write");

  // A write is never issued while the output register cannot take it.
  a_emit_ok: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> status.emit_ok)
    else $error("write issued while output stalled");

  // A new character is taken only after the previous one has been fully drawn.
  a_done_then_idle: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit && cmd.last) |=> req_ready)
    else $error("sequencer not idle after final write");

endmodule

// ===== design/dgpw_datapath.sv =====
// Datapath: configuration registers, pen position, row bases and the pixel write register.
// Depends on dgpw_pkg; commanded by dgpw_ctrl.
module dgpw_datapath #(
  parameter int unsigned FRAME_WORDS = dgpw_pkg::FRAME_WORDS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  input  dgpw_pkg::cfg_wr_t     cfg_req,
  output logic                  cfg_ready,
  input  dgpw_pkg::dp_cmd_t     cmd,
  output dgpw_pkg::dp_status_t  status,
  output logic                  out_valid,
  output dgpw_pkg::pixel_wr_t   out_data,
  input  logic                  out_ready
);
  import dgpw_pkg::*;

  localparam logic [FULL_W-1:0] FRAME_LIMIT = FULL_W'(FRAME_WORDS);

  logic [STRIDE_W-1:0] row_stride;
  logic [COORD_W-1:0]  origin_x;
  logic [COORD_W-1:0]  origin_y;
  logic [COLOR_W-1:0]  ink_color;
  logic [PEN_W-1:0]    pen_x;
  logic [BASE_W-1:0]   base_top;
  logic [BASE_W-1:0]   base_bot;
  logic                out_valid_r;
  logic [INDEX_W-1:0]  pixel_index;
  logic                out_of_range;
  logic                last_write;

  logic [ROW_W-1:0]    row_y;
  logic [BASE_W-1:0]   top_prod;
  logic [FULL_W-1:0]   full_index;
  logic [PEN_W:0]      pen_sum;

  assign cfg_ready = 1'b1;
  assign status.emit_ok = !out_valid_r || out_ready;

  assign row_y    = ROW_W'(origin_y) + (cmd.dot_row ? ROW_W'(DOT_Y_OFFSET) : ROW_W'(0));
  assign top_prod = BASE_W'(row_y) * BASE_W'(row_stride);
  assign full_index = FULL_W'(cmd.dy ? base_bot : base_top) + FULL_W'(pen_x)
                    + FULL_W'(cmd.xoff);
  assign pen_sum  = (PEN_W+1)'(pen_x)
                  + (PEN_W+1)'(cmd.dot_advance ? DOT_ADVANCE : DIGIT_ADVANCE);

  always_ff @(posedge clk) begin
    if (rst) begin
      row_stride <= ROW_STRIDE_RST;
      origin_x   <= '0;
      origin_y   <= '0;
      ink_color  <= INK_COLOR_RST;
    end else if (cfg_valid) begin
      unique case (cfg_req.reg_index)
        REG_ROW_STRIDE: row_stride <= cfg_req.wdata[STRIDE_W-1:0];
        REG_ORIGIN_X:   origin_x   <= cfg_req.wdata[COORD_W-1:0];
        REG_ORIGIN_Y:   origin_y   <= cfg_req.wdata[COORD_W-1:0];
        REG_INK_COLOR:  ink_color  <= cfg_req.wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pen_x <= '0;
    end else if (cmd.load_pen) begin
      pen_x <= PEN_W'(origin_x);
    end else if (cmd.advance_pen) begin
      pen_x <= pen_sum[PEN_W] ? PEN_MAX : pen_sum[PEN_W-1:0];
    end
  end

  // Row bases for the upper and lower pixel row of the current font row.
  always_ff @(posedge clk) begin
    if (cmd.load_top) begin
      base_top <= top_prod;
    end else if (cmd.next_row) begin
      base_top <= base_top + BASE_W'({row_stride, 1'b0});
    end
    if (cmd.load_bot) begin
      base_bot <= base_top + BASE_W'(row_stride);
    end else if (cmd.next_row) begin
      base_bot <= base_bot + BASE_W'({row_stride, 1'b0});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      pixel_index  <= full_index[INDEX_W-1:0];
      out_of_range <= (full_index >= FRAME_LIMIT);
      last_write   <= cmd.last;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_data.pixel_index  = pixel_index;
  assign out_data.pixel_value  = ink_color;
  assign out_data.out_of_range = out_of_range;
  assign out_data.last_write   = last_write;

  // A held write is never overwritten.
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (out_valid_r && !out_ready) |-> !cmd.emit)
    else $error("pending pixel write overwritten");

  // A pending write leaves only by being taken.
  a_drop_only_taken: assert property (@(posedge clk) disable iff (rst)
    $fell(out_valid_r) |-> $past(out_ready))
    else $error("pixel write dropped");

  // Pen reload and pen advance belong to different phases of a character.
  a_pen_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(cmd.load_pen && cmd.advance_pen))
    else $error("pen reload and advance together");

endmodule

// ===== design/digit_glyph_pixel_writer.sv =====
// Top level of the digit glyph pixel writer: joins the sequencer and the datapath.
// Depends on dgpw_pkg, dgpw_stream_if, dgpw_ctrl and dgpw_datapath.
//
// Usage. Characters arrive one request at a time on the chars channel; each request
// carries a text byte and a string_start flag that reloads the pen from origin_x.
// Digits are drawn from a 4x5 font at double size, a period as one 2x2 block; every
// other byte is consumed in the idle state without any pixel write. Each lit pixel
// leaves on the pixels channel as one request holding the frame word index, the ink
// color, an out-of-range flag against FRAME_WORDS and a flag on the final write.
// Registers are written through the cfg channel, which is always ready; write them
// only while no character is in progress.
//
// Timing. After a character is accepted, the sequencer sets up the row bases with the
// stride multiply in its load-top and load-bottom states, then issues one write per
// cycle while the pixel receiver holds ready high; the single output register bounds
// the write rate to one per cycle. A new character is taken the cycle after the final
// write has been issued into the output register.
//
// Stalls and reset. When the pixel receiver holds ready low the output register
// keeps its write and the sequencer waits without losing its place. Synchronous
// reset returns the sequencer to idle, empties the output register, sets the pen to
// zero and loads the register defaults (stride 640, origin 0, ink 0xFF0000FF).
module digit_glyph_pixel_writer #(
  parameter int unsigned FRAME_WORDS = dgpw_pkg::FRAME_WORDS_DEF
) (
  input logic          clk,
  input logic          rst,
  dgpw_stream_if.sink   chars,
  dgpw_stream_if.source pixels,
  dgpw_stream_if.sink   cfg
);
  import dgpw_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;
  char_req_t  char_req;
  cfg_wr_t    cfg_req;
  pixel_wr_t  pixel_req;

  // The channels carry package structs; unpack them explicitly at the boundary.
  assign char_req    = chars.data;
  assign cfg_req     = cfg.data;
  assign pixels.data = pixel_req;

  dgpw_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (chars.valid),
    .req       (char_req),
    .req_ready (chars.ready),
    .status    (status),
    .cmd       (cmd)
  );

  dgpw_datapath #(
    .FRAME_WORDS (FRAME_WORDS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg.valid),
    .cfg_req   (cfg_req),
    .cfg_ready (cfg.ready),
    .cmd       (cmd),
    .status    (status),
    .out_valid (pixels.valid),
    .out_data  (pixel_req),
    .out_ready (pixels.ready)
  );

endmodule
